// ----- rtl/mnhfe_pkg.sv -----
// Package for the message name hex field extractor.
// Holds the field limits, character codes and the hex digit decoder.
// No dependencies.
package mnhfe_pkg;

   // Field limits: a field holds at most limit-1 characters.
   localparam int TIME_FIELD_LIMIT = 17;
   localparam int INT_FIELD_LIMIT  = 9;

   // The field length counter must reach TIME_FIELD_LIMIT-1.
   localparam int FIELD_LEN_W = $clog2(TIME_FIELD_LIMIT);

   // Character codes.
   localparam logic [7:0] CHAR_END        = 8'h00;
   localparam logic [7:0] CHAR_SLASH      = 8'h2f;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

   // Decoded hex character.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   // Decodes 0-9, a-f and A-F; anything else is not a digit.
   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// ----- rtl/message_name_hex_field_extractor.sv -----
// Top level of the message name hex field extractor.
// Depends on mnhfe_pkg for limits, character codes and the hex decoder.
//
// The block takes a message name one character per beat and, at the zero
// byte that ends the name, returns one result beat with the creation time,
// unique number and split counter parsed from the name A/B/T_U_S, plus a
// flag that tells whether the name matched; on failure all values are zero.
// Characters are taken one per cycle, but for the stall below: each beat updates the
// parse state and the hex accumulators in the same cycle, and the result
// register lets the next name start while a result still waits to be
// taken. Input stalls only when a zero byte arrives while the previous
// result is still held and is not being taken.
module message_name_hex_field_extractor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_create_time,
   output logic [31:0] rsp_unique_id,
   output logic [31:0] rsp_split_counter,
   output logic        rsp_parse_ok
);

   typedef enum logic [2:0] {
      PH_SKIP1,
      PH_SKIP2,
      PH_TIME,
      PH_UNIQUE,
      PH_SPLIT,
      PH_DONE,
      PH_FAIL
   } phase_type;

   localparam int LW = mnhfe_pkg::FIELD_LEN_W;
   localparam logic [LW:0] TIME_LIMIT = (LW+1)'(mnhfe_pkg::TIME_FIELD_LIMIT);
   localparam logic [LW:0] INT_LIMIT  = (LW+1)'(mnhfe_pkg::INT_FIELD_LIMIT);

   phase_type          phase_ff, phase_in;
   logic [LW-1:0]      field_length_ff, field_length_in;
   logic               digits_stopped_ff, digits_stopped_in;
   logic [63:0]        time_acc_ff, time_acc_in;
   logic [31:0]        unique_acc_ff, unique_acc_in;
   logic [31:0]        split_acc_ff, split_acc_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_time_ff, rsp_time_in;
   logic [31:0]        rsp_unique_ff, rsp_unique_in;
   logic [31:0]        rsp_split_ff, rsp_split_in;
   logic               rsp_ok_ff, rsp_ok_in;

   logic                     accept;
   logic                     char_is_end;
   logic                     name_ok;
   logic [LW:0]              len_plus;
   logic [LW:0]              limit;
   mnhfe_pkg::hex_digit_type digit;

   // A zero byte may only enter when the result register is free or draining.
   assign req_ready   = !char_is_end || !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign char_is_end = (req_char_in == mnhfe_pkg::CHAR_END);
   assign digit       = mnhfe_pkg::hex_decode(req_char_in);
   assign len_plus    = {1'b0, field_length_ff} + (LW+1)'(1);
   assign limit       = (phase_ff == PH_TIME) ? TIME_LIMIT : INT_LIMIT;
   assign name_ok     = (phase_ff == PH_DONE) ||
                        (phase_ff == PH_SPLIT && field_length_ff != '0);

   // Parse state update for one character beat.
   always_comb begin
      phase_in          = phase_ff;
      field_length_in   = field_length_ff;
      digits_stopped_in = digits_stopped_ff;
      time_acc_in       = time_acc_ff;
      unique_acc_in     = unique_acc_ff;
      split_acc_in      = split_acc_ff;

      case (phase_ff)
         PH_SKIP1: begin
            if (req_char_in == mnhfe_pkg::CHAR_SLASH) begin
               phase_in = PH_SKIP2;
            end
         end
         PH_SKIP2: begin
            if (req_char_in == mnhfe_pkg::CHAR_SLASH) begin
               phase_in          = PH_TIME;
               field_length_in   = '0;
               digits_stopped_in = 1'b0;
               time_acc_in       = '0;
               unique_acc_in     = '0;
               split_acc_in      = '0;
            end
         end
         PH_TIME, PH_UNIQUE, PH_SPLIT: begin
            if (req_char_in == mnhfe_pkg::CHAR_UNDERSCORE) begin
               // An underscore closes the field unless the field is empty.
               if (field_length_ff == '0) begin
                  phase_in = PH_FAIL;
               end else begin
                  field_length_in   = '0;
                  digits_stopped_in = 1'b0;
                  case (phase_ff)
                     PH_TIME:   phase_in = PH_UNIQUE;
                     PH_UNIQUE: phase_in = PH_SPLIT;
                     default:   phase_in = PH_DONE;
                  endcase
               end
            end else if (len_plus >= limit) begin
               phase_in = PH_FAIL;
            end else begin
               // Count the character; leading hex digits shift into the value.
               field_length_in = len_plus[LW-1:0];
               if (!digits_stopped_ff) begin
                  if (!digit.valid) begin
                     digits_stopped_in = 1'b1;
                  end else begin
                     case (phase_ff)
                        PH_TIME:   time_acc_in   = {time_acc_ff[59:0], digit.value};
                        PH_UNIQUE: unique_acc_in = {unique_acc_ff[27:0], digit.value};
                        default:   split_acc_in  = {split_acc_ff[27:0], digit.value};
                     endcase
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // The end of a name returns the parser to its starting state.
      if (char_is_end) begin
         phase_in          = PH_SKIP1;
         field_length_in   = '0;
         digits_stopped_in = 1'b0;
         time_acc_in       = '0;
         unique_acc_in     = '0;
         split_acc_in      = '0;
      end
   end

   // Result register loads at the end of a name and empties when taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_time_in   = rsp_time_ff;
      rsp_unique_in = rsp_unique_ff;
      rsp_split_in  = rsp_split_ff;
      rsp_ok_in     = rsp_ok_ff;
      if (accept && char_is_end) begin
         rsp_valid_in  = 1'b1;
         rsp_time_in   = name_ok ? time_acc_ff : '0;
         rsp_unique_in = name_ok ? unique_acc_ff : '0;
         rsp_split_in  = name_ok ? split_acc_ff : '0;
         rsp_ok_in     = name_ok;
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_SKIP1;
         field_length_ff   <= '0;
         digits_stopped_ff <= 1'b0;
         time_acc_ff       <= '0;
         unique_acc_ff     <= '0;
         split_acc_ff      <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff          <= phase_in;
            field_length_ff   <= field_length_in;
            digits_stopped_ff <= digits_stopped_in;
            time_acc_ff       <= time_acc_in;
            unique_acc_ff     <= unique_acc_in;
            split_acc_ff      <= split_acc_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_time_ff   <= rsp_time_in;
      rsp_unique_ff <= rsp_unique_in;
      rsp_split_ff  <= rsp_split_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_create_time   = rsp_time_ff;
   assign rsp_unique_id     = rsp_unique_ff;
   assign rsp_split_counter = rsp_split_ff;
   assign rsp_parse_ok      = rsp_ok_ff;

   // A zero byte beat always produces a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept && char_is_end |=> rsp_valid_ff)
      else $error("end of name did not produce a result");

   // After a zero byte the parser is back at the start with clear values.
   assert property (@(posedge clock) disable iff (reset)
      accept && char_is_end |=> phase_ff == PH_SKIP1 && time_acc_ff == '0 &&
         unique_acc_ff == '0 && split_acc_ff == '0)
      else $error("parser not restarted after end of name");

   // A failed name reports all values as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_time_ff == '0 && rsp_unique_ff == '0 &&
         rsp_split_ff == '0)
      else $error("failed name carries nonzero values");

   // The field length never reaches the field limit; a failed name keeps
   // the length of the field it failed in.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, field_length_ff} < TIME_LIMIT) &&
      (phase_ff == PH_TIME || phase_ff == PH_FAIL ||
         {1'b0, field_length_ff} < INT_LIMIT))
      else $error("field length beyond limit");

endmodule

// ----- dv/message_name_hex_field_extractor_tb.sv -----
// Testbench for the message name hex field extractor: drives whole names one
// character per beat and checks each result beat against its own parser.
// Depends on mnhfe_pkg and the message_name_hex_field_extractor RTL.
module message_name_hex_field_extractor_tb;

   // Parse position within a name.
   typedef enum logic [2:0] {
      SKIP_FIRST, SKIP_SECOND, IN_TIME, IN_UNIQUE, IN_SPLIT, NAME_DONE, NAME_FAILED
   } parse_phase_type;

   // Receiver stall styles.
   typedef enum logic [1:0] {
      ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, SQUARE_WAVE
   } stall_style_type;

   // One result beat.
   typedef struct packed {
      logic [63:0] create_time;
      logic [31:0] unique_id;
      logic [31:0] split_counter;
      logic        parse_ok;
   } name_fields_type;

   // Tracks the parse of the current name and holds the fields still due.
   class name_scoreboard_type;
      parse_phase_type phase;
      int              field_len;
      bit              digits_stopped;
      logic [63:0]     time_acc;
      logic [31:0]     unique_acc;
      logic [31:0]     split_acc;
      name_fields_type fields_due[$];
      int              errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase          = SKIP_FIRST;
         field_len      = 0;
         digits_stopped = 1'b0;
         time_acc       = '0;
         unique_acc     = '0;
         split_acc      = '0;
      endfunction

      function int pending();
         return fields_due.size();
      endfunction

      // Value of a hex digit, or -1 for any other character.
      function int nibble_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - int'("0");
         if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
         if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
         return -1;
      endfunction

      // Advances the parse by one accepted character.
      function void note_char(logic [7:0] c);
         name_fields_type fields;
         bit              ok;
         int              limit;
         int              nib;
         // The end of the name yields one result and starts over.
         if (c == mnhfe_pkg::CHAR_END) begin
            ok = (phase == NAME_DONE) || (phase == IN_SPLIT && field_len > 0);
            fields = '0;
            if (ok) begin
               fields.create_time   = time_acc;
               fields.unique_id     = unique_acc;
               fields.split_counter = split_acc;
               fields.parse_ok      = 1'b1;
            end
            fields_due.push_back(fields);
            clear_state();
            return;
         end
         case (phase)
            SKIP_FIRST: begin
               if (c == mnhfe_pkg::CHAR_SLASH) phase = SKIP_SECOND;
            end
            SKIP_SECOND: begin
               if (c == mnhfe_pkg::CHAR_SLASH) begin
                  phase          = IN_TIME;
                  field_len      = 0;
                  digits_stopped = 1'b0;
                  time_acc       = '0;
                  unique_acc     = '0;
                  split_acc      = '0;
               end
            end
            IN_TIME, IN_UNIQUE, IN_SPLIT: begin
               if (c == mnhfe_pkg::CHAR_UNDERSCORE) begin
                  // An empty field fails the name.
                  if (field_len == 0) begin
                     phase = NAME_FAILED;
                  end else begin
                     phase = (phase == IN_TIME) ? IN_UNIQUE :
                             (phase == IN_UNIQUE) ? IN_SPLIT : NAME_DONE;
                     field_len      = 0;
                     digits_stopped = 1'b0;
                  end
               end else begin
                  limit = (phase == IN_TIME) ? mnhfe_pkg::TIME_FIELD_LIMIT :
                                               mnhfe_pkg::INT_FIELD_LIMIT;
                  if (field_len + 1 >= limit) begin
                     phase = NAME_FAILED;
                  end else begin
                     field_len++;
                     // The first non-hex character freezes the value.
                     if (!digits_stopped) begin
                        nib = nibble_of(c);
                        if (nib < 0) begin
                           digits_stopped = 1'b1;
                        end else if (phase == IN_TIME) begin
                           time_acc = {time_acc[59:0], nib[3:0]};
                        end else if (phase == IN_UNIQUE) begin
                           unique_acc = {unique_acc[27:0], nib[3:0]};
                        end else begin
                           split_acc = {split_acc[27:0], nib[3:0]};
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      // Compares a result beat with the oldest fields due.
      function void check_result(name_fields_type seen);
         name_fields_type want;
         if (fields_due.size() == 0) begin
            $display("%0t: result beat with none due: time %h unique %h split %h ok %b",
                     $time, seen.create_time, seen.unique_id, seen.split_counter,
                     seen.parse_ok);
            errors++;
            return;
         end
         want = fields_due.pop_front();
         if (seen.create_time !== want.create_time) begin
            $display("%0t: create_time expected %h actual %h",
                     $time, want.create_time, seen.create_time);
            errors++;
         end
         if (seen.unique_id !== want.unique_id) begin
            $display("%0t: unique_id expected %h actual %h",
                     $time, want.unique_id, seen.unique_id);
            errors++;
         end
         if (seen.split_counter !== want.split_counter) begin
            $display("%0t: split_counter expected %h actual %h",
                     $time, want.split_counter, seen.split_counter);
            errors++;
         end
         if (seen.parse_ok !== want.parse_ok) begin
            $display("%0t: parse_ok expected %b actual %b",
                     $time, want.parse_ok, seen.parse_ok);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = mnhfe_pkg::CHAR_END;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_create_time;
   logic [31:0] rsp_unique_id;
   logic [31:0] rsp_split_counter;
   logic        rsp_parse_ok;

   name_scoreboard_type sb;
   logic [7:0]      name_chars[$];
   int              chars_sent = 0;
   int              burst_left = 0;
   stall_style_type stall_style = ALWAYS_READY;
   int              stall_left = 0;
   int              wave_count = 0;

   message_name_hex_field_extractor i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_in       (req_char_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_create_time   (rsp_create_time),
      .rsp_unique_id     (rsp_unique_id),
      .rsp_split_counter (rsp_split_counter),
      .rsp_parse_ok      (rsp_parse_ok)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stalls in styles that change at random.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 3));
         stall_left  = $urandom_range(20, 100);
      end
      stall_left--;
      wave_count++;
      case (stall_style)
         ALWAYS_READY:   rsp_ready <= 1'b1;
         COIN_FLIP:      rsp_ready <= 1'($urandom_range(0, 1));
         MOSTLY_STALLED: rsp_ready <= ($urandom_range(0, 7) == 0);
         default:        rsp_ready <= wave_count[2];
      endcase
   end

   // Every accepted result beat goes to the scoreboard.
   always @(posedge clock) begin : result_monitor
      name_fields_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.create_time   = rsp_create_time;
         seen.unique_id     = rsp_unique_id;
         seen.split_counter = rsp_split_counter;
         seen.parse_ok      = rsp_parse_ok;
         sb.check_result(seen);
      end
   end

   // A hex digit in either case.
   function automatic logic [7:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   // Any character but the end of the name.
   function automatic logic [7:0] noise_char();
      return 8'($urandom_range(1, 255));
   endfunction

   // Field content: mostly hex digits, now and then something else.
   function automatic logic [7:0] field_char();
      logic [7:0] c;
      if ($urandom_range(0, 7) != 0) return hex_char();
      c = noise_char();
      if (c == mnhfe_pkg::CHAR_UNDERSCORE) c = 8'h7e;
      return c;
   endfunction

   function automatic void push_field(int len);
      repeat (len) name_chars.push_back(field_char());
   endfunction

   // Text of a skipped field, free of slashes, then the slash that closes it.
   function automatic void push_skip_text();
      logic [7:0] c;
      repeat ($urandom_range(0, 4)) begin
         c = noise_char();
         if (c == mnhfe_pkg::CHAR_SLASH) c = "x";
         name_chars.push_back(c);
      end
      name_chars.push_back(mnhfe_pkg::CHAR_SLASH);
   endfunction

   // Field length: mostly legal, sometimes empty, full or one too long.
   function automatic int pick_len(int limit);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return limit;
      if (r <= 4) return limit - 1;
      return $urandom_range(1, limit - 1);
   endfunction

   function automatic void load_text(string s);
      name_chars.delete();
      for (int i = 0; i < s.len(); i++) name_chars.push_back(s[i]);
      name_chars.push_back(mnhfe_pkg::CHAR_END);
   endfunction

   // Builds a random name: mostly well formed, some cut short, some noise.
   function automatic void build_random_name();
      int kind;
      int cut;
      kind = $urandom_range(0, 9);
      name_chars.delete();
      if (kind == 0) begin
         repeat ($urandom_range(0, 30)) name_chars.push_back(noise_char());
      end else begin
         push_skip_text();
         push_skip_text();
         push_field(pick_len(mnhfe_pkg::TIME_FIELD_LIMIT));
         name_chars.push_back(mnhfe_pkg::CHAR_UNDERSCORE);
         push_field(pick_len(mnhfe_pkg::INT_FIELD_LIMIT));
         name_chars.push_back(mnhfe_pkg::CHAR_UNDERSCORE);
         push_field(pick_len(mnhfe_pkg::INT_FIELD_LIMIT));
         if ($urandom_range(0, 2) == 0) begin
            name_chars.push_back(mnhfe_pkg::CHAR_UNDERSCORE);
            repeat ($urandom_range(0, 5)) name_chars.push_back(noise_char());
         end
         // Broken names stop somewhere along the way.
         if (kind == 1) begin
            cut = $urandom_range(0, name_chars.size());
            while (name_chars.size() > cut) void'(name_chars.pop_back());
         end
      end
      name_chars.push_back(mnhfe_pkg::CHAR_END);
   endfunction

   // Sends the queued name in bursts with random gaps.
   task automatic send_name();
      int gap;
      foreach (name_chars[i]) begin
         if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid   <= 1'b1;
         req_char_in <= name_chars[i];
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sb.note_char(name_chars[i]);
         chars_sent++;
         burst_left--;
      end
   endtask

   // Holds the sender off until every result due has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic send_text(string s);
      load_text(s);
      send_name();
   endtask

   initial begin
      int random_names;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed names: extremes, tail after the split counter, special cases.
      send_text("//ffffffffffffffff_ffffffff_ffffffff");
      send_text("a/b/0_0_0_x");
      send_text("//10000000000000000_1_1");
      send_text("//1__2");
      send_text("//1_2");
      send_text("");
      send_text("x/y/AbCdEf_g1_12345678Z");
      send_text("//1_123456789_1");
      drain_results();

      // Random names until enough characters have gone through.
      random_names = 0;
      while (chars_sent < 900) begin
         build_random_name();
         send_name();
         random_names++;
         if (random_names == 10) drain_results();
      end
      req_valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("message_name_hex_field_extractor: match");
      end else begin
         $display("message_name_hex_field_extractor: mismatch");
      end
      $finish;
   end

   // Run limit well beyond the slowest correct run.
   initial begin
      #1000000;
      $display("message_name_hex_field_extractor: mismatch");
      $finish;
   end

endmodule

// ----- message_name_hex_field_extractor.f -----
rtl/mnhfe_pkg.sv
rtl/message_name_hex_field_extractor.sv
dv/message_name_hex_field_extractor_tb.sv
